[rtl/core/armed_combination_lock_defines.svh]
// Assertion macros used by the back part of the lock.
`ifndef ARMED_COMBINATION_LOCK_DEFINES_SVH
`define ARMED_COMBINATION_LOCK_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define ACL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define ACL_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

[rtl/core/acl_pkg.sv]
// Types and constants of the armed combination lock.
`default_nettype none

package acl_pkg;

  // Key and entry sizes
  localparam int KeyLength = 5;
  localparam int KeyW      = 10;
  localparam int CntW      = $clog2(KeyLength + 1);
  localparam int TicksW    = 8;

  // Event kinds
  localparam logic [1:0] ActTick   = 2'd0;
  localparam logic [1:0] ActMotion = 2'd1;
  localparam logic [1:0] ActButton = 2'd2;

  // Register indexes
  localparam logic CfgKey   = 1'b0;
  localparam logic CfgTicks = 1'b1;

  // Reset values of the registers
  localparam logic [KeyW-1:0]   KeyReset   = 10'd377;
  localparam logic [TicksW-1:0] TicksReset = 8'd10;

  // Intruder message
  localparam int MsgLen  = 10;
  localparam int MsgIdxW = $clog2(MsgLen);
  localparam logic [7:0] IntruderMsg [MsgLen] = '{
    8'd73, 8'd110, 8'd116, 8'd114, 8'd117, 8'd100, 8'd101, 8'd114, 8'd10, 8'd13
  };

  // Queue between front and back
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // One classified item handed from front to back
  typedef struct packed {
    logic led;
    logic buzzer;
    logic armed;
    logic alarm_msg;
  } job_t;

  // Key digit at a position; positions past the register read as zero
  function automatic logic [1:0] key_digit(input logic [KeyW-1:0] key, input int pos);
    logic [1:0] d;
    d = 2'd0;
    if (2 * pos < KeyW) begin
      d = 2'(key >> (2 * pos));
    end
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/core/armed_combination_lock.sv]
// Armed combination lock: front classifier, item queue and result sequencer.
// An accepted item is written into the queue and then loaded into the output register.
// Throughput: one item per cycle while results are taken; a wrong entry holds the
// output while the ten message bytes leave, and the four-entry queue absorbs items.
// Reset (rst_ni low, asynchronous): lock unarmed, no digits, alarm and LED off,
// queue and output empty, key 377 and alarm ticks 10.
`default_nettype none

module armed_combination_lock (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [1:0] digit, [7:2] zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [0] status_led, [1] buzzer, [2] armed,
                                           // [10:3] tx_byte, [15:11] zero
  output logic             m_axis_tuser,   // [0] tx_valid
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [9:0]  cfg_data_i
);
  import acl_pkg::*;

  job_t       push_job, pop_job;
  logic       push, pop, q_full, q_empty;
  logic       led, buzzer, armed;
  logic [7:0] tx_byte;

  assign cfg_ready_o = 1'b1;

  acl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser),
    .digit_i     (s_axis_tdata[1:0]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  acl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_job),
    .empty_o (q_empty)
  );

  acl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .led_o       (led),
    .buzzer_o    (buzzer),
    .armed_o     (armed),
    .tx_valid_o  (m_axis_tuser),
    .tx_byte_o   (tx_byte),
    .last_o      (m_axis_tlast)
  );

  // Pack the result fields
  assign m_axis_tdata = {5'd0, tx_byte, armed, buzzer, led};

endmodule

`default_nettype wire

[rtl/core/acl_front.sv]
// Front part: takes events and registers, updates the lock state, classifies items.
`default_nettype none

module acl_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            action_i,
  input  wire logic [1:0]            digit_i,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_index_i,
  input  wire logic [9:0]            cfg_data_i,
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output acl_pkg::job_t              job_o
);
  import acl_pkg::*;

  logic [KeyW-1:0]   key_q;
  logic [TicksW-1:0] ticks_q;
  logic              armed_q, armed_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        entered_q [KeyLength];
  logic [1:0]        entered_d [KeyLength];
  logic [TicksW-1:0] alarm_q, alarm_d;
  logic              led_q, led_d;
  logic              alarm_running;
  logic              take_digit;
  logic              complete;
  logic              match;
  logic              msg;

  assign in_ready_o    = !q_full_i;
  assign push_o        = in_valid_i && in_ready_o;
  assign alarm_running = (alarm_q != '0);
  assign take_digit    = (action_i == ActButton) && !alarm_running && armed_q &&
                         (digit_i != 2'd0) && (cnt_q < CntW'(KeyLength));
  assign complete      = take_digit && (cnt_q == CntW'(KeyLength - 1));

  // Compare the finished entry, with the incoming digit in the final position
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < KeyLength; i++) begin
      if (i == KeyLength - 1) begin
        if (digit_i != key_digit(key_q, i)) match = 1'b0;
      end else begin
        if (entered_q[i] != key_digit(key_q, i)) match = 1'b0;
      end
    end
  end

  // Next state of the lock
  always_comb begin
    armed_d   = armed_q;
    cnt_d     = cnt_q;
    entered_d = entered_q;
    alarm_d   = alarm_q;
    led_d     = led_q;
    msg       = 1'b0;
    unique case (action_i)
      ActTick: begin
        if (alarm_running) alarm_d = alarm_q - 1'b1;
      end
      ActMotion: begin
        if (!alarm_running) armed_d = 1'b1;
      end
      ActButton: begin
        if (take_digit) begin
          for (int i = 0; i < KeyLength; i++) begin
            if (cnt_q == CntW'(i)) entered_d[i] = digit_i;
          end
          cnt_d = cnt_q + 1'b1;
          if (complete) begin
            armed_d = 1'b0;
            cnt_d   = '0;
            for (int i = 0; i < KeyLength; i++) entered_d[i] = 2'd0;
            if (match) begin
              led_d = 1'b1;
            end else begin
              led_d   = 1'b0;
              alarm_d = ticks_q;
              msg     = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Describe the results of this item
  always_comb begin
    job_o.led       = led_d;
    job_o.buzzer    = (alarm_d != '0);
    job_o.armed     = armed_d;
    job_o.alarm_msg = msg;
  end

  // Hold registers and lock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= KeyReset;
      ticks_q <= TicksReset;
      armed_q <= 1'b0;
      cnt_q   <= '0;
      alarm_q <= '0;
      led_q   <= 1'b0;
      for (int i = 0; i < KeyLength; i++) entered_q[i] <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgKey:   key_q   <= cfg_data_i;
          CfgTicks: ticks_q <= cfg_data_i[TicksW-1:0];
          default: ;
        endcase
      end
      if (push_o) begin
        armed_q   <= armed_d;
        cnt_q     <= cnt_d;
        entered_q <= entered_d;
        alarm_q   <= alarm_d;
        led_q     <= led_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/acl_fifo.sv]
// Short queue of classified items between front and back.
`default_nettype none

module acl_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire acl_pkg::job_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output acl_pkg::job_t      data_o,
  output logic               empty_o
);
  import acl_pkg::*;

  job_t           mem_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QAw:0]   cnt_q;

  assign full_o  = (cnt_q == (QAw + 1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/acl_back.sv]
// Back part: turns queued items into results and sends the intruder message.
`default_nettype none

module acl_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire acl_pkg::job_t job_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               led_o,
  output logic               buzzer_o,
  output logic               armed_o,
  output logic               tx_valid_o,
  output logic [7:0]         tx_byte_o,
  output logic               last_o
);
  import acl_pkg::*;
  `include "armed_combination_lock_defines.svh"

  logic               out_valid_q;
  logic               led_q, buzzer_q, armed_q, tx_valid_q, last_q;
  logic [7:0]         byte_q;
  logic [MsgIdxW-1:0] idx_q;
  logic               msg_active;
  logic               load;

  assign msg_active  = (idx_q != '0);
  assign load        = !out_valid_q || out_ready_i;
  assign pop_o       = load && !msg_active && !empty_i;

  assign out_valid_o = out_valid_q;
  assign led_o       = led_q;
  assign buzzer_o    = buzzer_q;
  assign armed_o     = armed_q;
  assign tx_valid_o  = tx_valid_q;
  assign tx_byte_o   = byte_q;
  assign last_o      = last_q;

  // Load the output register from the message run or the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      led_q       <= 1'b0;
      buzzer_q    <= 1'b0;
      armed_q     <= 1'b0;
      tx_valid_q  <= 1'b0;
      byte_q      <= '0;
      last_q      <= 1'b0;
    end else if (load) begin
      if (msg_active) begin
        out_valid_q <= 1'b1;
        byte_q      <= IntruderMsg[idx_q];
        last_q      <= (idx_q == MsgIdxW'(MsgLen - 1));
        idx_q       <= (idx_q == MsgIdxW'(MsgLen - 1)) ? '0 : idx_q + 1'b1;
      end else if (!empty_i) begin
        out_valid_q <= 1'b1;
        led_q       <= job_i.led;
        buzzer_q    <= job_i.buzzer;
        armed_q     <= job_i.armed;
        tx_valid_q  <= job_i.alarm_msg;
        byte_q      <= job_i.alarm_msg ? IntruderMsg[0] : 8'd0;
        last_q      <= !job_i.alarm_msg;
        idx_q       <= job_i.alarm_msg ? MsgIdxW'(1) : '0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `ACL_ASSERT(a_idx_range, idx_q < MsgIdxW'(MsgLen), "message index out of range")
  `ACL_ASSERT(a_status_last, !(out_valid_q && !tx_valid_q) || last_q, "status result without last")
  `ACL_ASSERT_NEXT(a_run_holds, msg_active, out_valid_q && tx_valid_q, "message run lost its output")

endmodule

`default_nettype wire

[tb/armed_combination_lock_checker.sv]
// Checker for the armed combination lock: predicts each status item and compares it.
`default_nettype none

module armed_combination_lock_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  in_data_i,    // [1:0] digit, [7:2] zero
  input  wire logic [1:0]  in_user_i,    // [1:0] action
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [15:0] out_data_i,   // [0] status_led, [1] buzzer, [2] armed,
                                         // [10:3] tx_byte, [15:11] zero
  input  wire logic        out_user_i,   // [0] tx_valid
  input  wire logic        out_last_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic        cfg_index_i,
  input  wire logic [9:0]  cfg_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  import acl_pkg::*;

  // "Intruder" followed by line feed and carriage return
  localparam int AlarmTextLen = 10;
  localparam logic [7:0] AlarmText [AlarmTextLen] = '{
    8'd73, 8'd110, 8'd116, 8'd114, 8'd117, 8'd100, 8'd101, 8'd114, 8'd10, 8'd13
  };

  typedef struct packed {
    logic       led;
    logic       buzzer;
    logic       armed;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
  } lock_status_t;

  lock_status_t status_due_q [$];

  // Predicted lock state and registers
  logic              armed_q;
  logic [2:0]        entered_cnt;
  logic [1:0]        entered [KeyLength];
  logic [7:0]        alarm_left;
  logic              led_q;
  logic [KeyW-1:0]   key_q;
  logic [TicksW-1:0] ticks_q;

  // Queue one status item as seen after the event has been applied
  task automatic queue_status(input logic tx_valid, input logic [7:0] tx_byte,
                              input logic last);
    lock_status_t s;
    s.led      = led_q;
    s.buzzer   = (alarm_left != 8'd0);
    s.armed    = armed_q;
    s.tx_valid = tx_valid;
    s.tx_byte  = tx_valid ? tx_byte : 8'd0;
    s.last     = last;
    status_due_q.push_back(s);
  endtask

  // Apply one lock event and queue the status items it causes
  task automatic apply_lock_event(input logic [1:0] act, input logic [1:0] dig);
    logic busy;
    logic hit;
    int   i;
    busy = (alarm_left != 8'd0);
    hit  = 1'b1;
    case (act)
      ActTick: begin
        if (busy) alarm_left = alarm_left - 8'd1;
      end
      ActMotion: begin
        if (!busy) armed_q = 1'b1;
      end
      ActButton: begin
        if (!busy && armed_q && dig != 2'd0 && entered_cnt < KeyLength) begin
          entered[entered_cnt] = dig;
          entered_cnt = entered_cnt + 3'd1;
          if (entered_cnt >= KeyLength) begin
            // Digits past the key register never match
            for (i = 0; i < KeyLength; i++) begin
              if (entered[i] != ((2 * i < KeyW) ? key_q[2 * i +: 2] : 2'd0)) hit = 1'b0;
            end
            armed_q     = 1'b0;
            entered_cnt = 3'd0;
            for (i = 0; i < KeyLength; i++) entered[i] = 2'd0;
            if (hit) begin
              led_q = 1'b1;
            end else begin
              led_q      = 1'b0;
              alarm_left = ticks_q;
              for (i = 0; i < AlarmTextLen; i++) begin
                queue_status(1'b1, AlarmText[i], i == AlarmTextLen - 1);
              end
              return;
            end
          end
        end
      end
      default: ;
    endcase
    queue_status(1'b0, 8'd0, 1'b1);
  endtask

  // Flag one field that differs from its prediction
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Track registers and events, compare every accepted status item
  always @(posedge clk_i or negedge rst_ni) begin : watch
    lock_status_t due;
    int           i;
    if (!rst_ni) begin
      armed_q      = 1'b0;
      entered_cnt  = 3'd0;
      for (i = 0; i < KeyLength; i++) entered[i] = 2'd0;
      alarm_left   = 8'd0;
      led_q        = 1'b0;
      key_q        = KeyReset;
      ticks_q      = TicksReset;
      fail_count_o = 0;
      checked_o    = 0;
      status_due_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgKey:   key_q   = cfg_data_i;
          CfgTicks: ticks_q = cfg_data_i[TicksW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (status_due_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: status item with nothing expected, actual data %h tx_valid %b last %b",
                   $time, out_data_i, out_user_i, out_last_i);
        end else begin
          due = status_due_q.pop_front();
          check_field("status_led", int'(due.led), int'(out_data_i[0]));
          check_field("buzzer", int'(due.buzzer), int'(out_data_i[1]));
          check_field("armed", int'(due.armed), int'(out_data_i[2]));
          check_field("tx_valid", int'(due.tx_valid), int'(out_user_i));
          check_field("tx_byte", int'(due.tx_byte), int'(out_data_i[10:3]));
          check_field("last", int'(due.last), int'(out_last_i));
          checked_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_lock_event(in_user_i, in_data_i[1:0]);
      end
    end
    pending_o <= status_due_q.size();
  end

endmodule

`default_nettype wire

[tb/armed_combination_lock_test.sv]
// Testbench top for the armed combination lock: stimulus, idling and verdict.
`default_nettype none

module armed_combination_lock_test;

  import acl_pkg::*;

  localparam int          CycleLimit  = 300000;
  localparam int          HoldCycles  = 80;
  localparam int          DrainCycles = 8;
  localparam logic [1:0]  ActUnused   = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [9:0]  cfg_data;

  int fail_count;
  int pending;
  int checked;
  int cycle_count;
  int events_sent;
  int cfg_writes;

  // Shared knobs between stimulus and receiver
  logic        calm;
  logic        hold_go;
  logic        hold_done;
  logic [9:0]  cur_key;
  logic [7:0]  cur_ticks;

  armed_combination_lock u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  armed_combination_lock_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .out_last_i   (m_axis_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort on a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d status items outstanding", cycle_count, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin
    m_axis_tready <= 1'b0;
    hold_done     <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done <= 1'b1;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Offer one event item and hold it until accepted
  task automatic send_event(input logic [1:0] act, input logic [1:0] dig);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'd0, dig};
    do @(posedge clk); while (!s_axis_tready);
    events_sent++;
  endtask

  // Stop offering and wait until every predicted status item has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Write one register while the lock is idle
  task automatic write_reg(input logic idx, input logic [9:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Switch key and alarm length between phases
  task automatic set_lock(input logic [9:0] key, input logic [7:0] ticks);
    wait_drained();
    write_reg(CfgKey, key);
    write_reg(CfgTicks, {2'd0, ticks});
    cur_key   = key;
    cur_ticks = ticks;
  endtask

  // Mostly full entries after motion, some cut short, the rest random noise
  task automatic run_random(input int count);
    int         start;
    int         k;
    int         n_btn;
    logic       want;
    logic [1:0] dig;
    start = events_sent;
    while (events_sent - start < count) begin
      if ($urandom_range(0, 9) < 7) begin
        want  = 1'($urandom_range(0, 1));
        n_btn = ($urandom_range(0, 4) == 0) ? $urandom_range(1, KeyLength - 1) : KeyLength;
        send_event(ActMotion, 2'($urandom_range(0, 3)));
        for (k = 0; k < n_btn; k++) begin
          if ($urandom_range(0, 7) == 0) send_event(ActTick, 2'($urandom_range(0, 3)));
          dig = want ? cur_key[2 * k +: 2] : 2'($urandom_range(1, 3));
          send_event(ActButton, dig);
        end
        repeat ($urandom_range(0, cur_ticks + 2)) send_event(ActTick, 2'($urandom_range(0, 3)));
      end else begin
        send_event(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      end
    end
  endtask

  // Random key whose digits are all pressable buttons
  function automatic logic [9:0] pressable_key();
    logic [9:0] key;
    int         i;
    for (i = 0; i < KeyLength; i++) key[2 * i +: 2] = 2'($urandom_range(1, 3));
    return key;
  endfunction

  // Stimulus and verdict
  initial begin : stimulus
    int         i;
    logic [1:0] bad;
    rst_n         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    s_axis_tuser  <= ActTick;
    cfg_valid     <= 1'b0;
    cfg_index     <= CfgKey;
    cfg_data      <= 10'd0;
    calm          <= 1'b0;
    hold_go       <= 1'b0;
    events_sent   = 0;
    cfg_writes    = 0;
    cur_key       = KeyReset;
    cur_ticks     = TicksReset;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored events, re-arm, correct and wrong entry under reset settings
    send_event(ActButton, 2'd1);
    send_event(ActTick, 2'd3);
    send_event(ActUnused, 2'd2);
    send_event(ActMotion, 2'd0);
    send_event(ActMotion, 2'd3);
    send_event(ActButton, 2'd0);
    send_event(ActButton, 2'd1);
    send_event(ActButton, 2'd2);
    send_event(ActButton, 2'd3);
    send_event(ActMotion, 2'd1);
    send_event(ActButton, 2'd1);
    send_event(ActButton, 2'd1);
    send_event(ActMotion, 2'd2);
    repeat (KeyLength) send_event(ActButton, 2'd3);
    send_event(ActMotion, 2'd0);
    send_event(ActButton, 2'd2);
    repeat (TicksReset) send_event(ActTick, 2'd1);

    // All-zero key never matches, shortest alarm
    set_lock(10'd0, 8'd1);
    run_random(30);

    // All-threes key; pause mid-phase until every status item is back
    set_lock(10'h3FF, 8'd3);
    run_random(15);
    wait_drained();
    run_random(15);

    // Zero alarm ticks: buzzer already off during the message
    set_lock(pressable_key(), 8'd0);
    run_random(30);

    // Long alarm with the top count bit set: wrong entry, events during it, full countdown
    set_lock(pressable_key(), 8'd128);
    send_event(ActMotion, 2'd0);
    for (i = 0; i < KeyLength; i++) begin
      bad = (cur_key[2 * i +: 2] == 2'd3) ? 2'd1 : cur_key[2 * i +: 2] + 2'd1;
      send_event(ActButton, bad);
    end
    send_event(ActMotion, 2'd1);
    send_event(ActButton, 2'd2);
    repeat (129) send_event(ActTick, 2'($urandom_range(0, 3)));
    send_event(ActMotion, 2'd3);
    for (i = 0; i < KeyLength; i++) send_event(ActButton, cur_key[2 * i +: 2]);

    // Bulk: long receiver hold-off, then a final stretch without idling
    set_lock(pressable_key(), 8'($urandom_range(2, 6)));
    run_random(20);
    hold_go <= 1'b1;
    run_random(30);
    calm <= 1'b1;
    run_random(35);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d lock events over six key and alarm settings (%0d register writes),",
             events_sent, cfg_writes);
    $display("checked %0d status items including wrong-entry messages and a full 128-tick alarm.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/acl_pkg.sv
rtl/core/acl_front.sv
rtl/core/acl_fifo.sv
rtl/core/acl_back.sv
rtl/core/armed_combination_lock.sv
tb/armed_combination_lock_checker.sv
tb/armed_combination_lock_test.sv
